### rtl/core/pces_pkg.sv
// Package for the configuration enumeration sequencer: field widths, codes,
// the queue entry type and the position stepping function.
// Depends on nothing; every other file of the block uses it.
package pces_pkg;

    localparam int BUS_W    = 8;
    localparam int SLOT_W   = 5;
    localparam int FUNC_W   = 3;
    localparam int OFF_W    = 8;
    localparam int ID_W     = 16;
    localparam int CODE_W   = 8;
    localparam int CNT_W    = 17;
    localparam int DATA_W   = 32;
    localparam int KIND_W   = 2;

    localparam logic [CNT_W-1:0]  CNT_MAX       = 17'h1FFFF;
    localparam logic [CNT_W-1:0]  MAX_RESET     = 17'd32;
    localparam logic [ID_W-1:0]   VENDOR_NONE   = 16'hFFFF;
    localparam logic [OFF_W-1:0]  OFFSET_ID     = 8'h00;
    localparam logic [OFF_W-1:0]  OFFSET_CLASS  = 8'h08;
    localparam logic [OFF_W-1:0]  OFFSET_HDR    = 8'h0C;
    localparam int                MULTI_BIT     = 23;
    localparam logic [FUNC_W-1:0] FUNC_LAST     = 3'd7;
    localparam logic [SLOT_W-1:0] SLOT_LAST     = 5'd31;
    localparam logic [BUS_W-1:0]  BUS_LAST      = 8'd255;

    localparam logic CMD_START    = 1'b0;
    localparam logic CMD_RESPONSE = 1'b1;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        PHASE_IDLE  = 2'd0,
        PHASE_ID    = 2'd1,
        PHASE_CLASS = 2'd2,
        PHASE_HDR   = 2'd3
    } phase_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_REQUEST = 2'd0,
        KIND_RECORD  = 2'd1,
        KIND_DONE    = 2'd2
    } kind_t;

    typedef struct packed {
        logic [BUS_W-1:0]  bus;
        logic [SLOT_W-1:0] slot;
        logic [FUNC_W-1:0] func;
    } pos_t;

    typedef struct packed {
        pos_t pos;
        logic exhausted;
    } adv_t;

    typedef struct packed {
        kind_t              kind;
        pos_t               pos;
        logic [OFF_W-1:0]   offset;
        logic [ID_W-1:0]    vendor;
        logic [ID_W-1:0]    device;
        logic [CODE_W-1:0]  class_code;
        logic [CODE_W-1:0]  subclass_code;
        logic [CNT_W-1:0]   count;
        logic               pair;
    } entry_t;

    function automatic adv_t advance(pos_t p, logic skip_slot);
        adv_t a;
        a = '0;
        a.pos = p;
        if (!skip_slot && p.func != FUNC_LAST)
        begin
            a.pos.func = p.func + 3'd1;
        end
        else
        begin
            a.pos.func = '0;
            if (p.slot != SLOT_LAST)
            begin
                a.pos.slot = p.slot + 5'd1;
            end
            else
            begin
                a.pos.slot = '0;
                if (p.bus != BUS_LAST)
                begin
                    a.pos.bus = p.bus + 8'd1;
                end
                else
                begin
                    a.pos.bus = '0;
                    a.exhausted = 1'b1;
                end
            end
        end
        return a;
    endfunction

endpackage

### rtl/core/pces_ifs.sv
// Handshake interfaces of the sequencer: input items, result beats and
// configuration writes. Depends on pces_pkg for the field widths.
interface pces_item_if;
    logic                         valid;
    logic                         ready;
    logic                         command;
    logic [pces_pkg::DATA_W-1:0]  read_data;
    modport source (output valid, output command, output read_data, input ready);
    modport sink (input valid, input command, input read_data, output ready);
endinterface

interface pces_result_if;
    logic                         valid;
    logic                         ready;
    logic [pces_pkg::KIND_W-1:0]  kind;
    logic [pces_pkg::BUS_W-1:0]   bus_number;
    logic [pces_pkg::SLOT_W-1:0]  slot_number;
    logic [pces_pkg::FUNC_W-1:0]  function_number;
    logic [pces_pkg::OFF_W-1:0]   register_offset;
    logic [pces_pkg::ID_W-1:0]    vendor_id;
    logic [pces_pkg::ID_W-1:0]    device_id;
    logic [pces_pkg::CODE_W-1:0]  class_code;
    logic [pces_pkg::CODE_W-1:0]  subclass_code;
    logic [pces_pkg::CNT_W-1:0]   found_count;
    logic                         last;
    modport source (output valid, output kind, output bus_number, output slot_number,
                    output function_number, output register_offset, output vendor_id,
                    output device_id, output class_code, output subclass_code,
                    output found_count, output last, input ready);
    modport sink (input valid, input kind, input bus_number, input slot_number,
                  input function_number, input register_offset, input vendor_id,
                  input device_id, input class_code, input subclass_code,
                  input found_count, input last, output ready);
endinterface

interface pces_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [pces_pkg::CNT_W-1:0]   data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/core/pces_front.sv
// Front end: accepts commands and read responses, walks the position and
// pushes one entry per productive beat. Depends on pces_pkg and pces_ifs.
module pces_front
(
    input  logic              clk,
    input  logic              rst_n,
    pces_item_if.sink         item,
    pces_cfg_if.sink          cfg,
    output pces_pkg::entry_t  push_entry,
    output logic              push_valid,
    input  logic              push_ready
);

    pces_pkg::phase_t                phase_reg, phase_next;
    pces_pkg::pos_t                  pos_reg, pos_next;
    logic [pces_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [pces_pkg::DATA_W-1:0]     saved_reg, saved_next;
    logic [pces_pkg::CNT_W-1:0]      max_reg;

    logic                            accept;
    logic                            fin_en;
    pces_pkg::adv_t                  fin_adv;
    pces_pkg::adv_t                  step;

    assign item.ready = push_ready;
    assign cfg.ready  = 1'b1;
    assign accept     = item.valid && push_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= pces_pkg::PHASE_IDLE;
            pos_reg   <= '0;
            count_reg <= '0;
            saved_reg <= '0;
            max_reg   <= pces_pkg::MAX_RESET;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            count_reg <= count_next;
            saved_reg <= saved_next;
            if (cfg.valid)
            begin
                max_reg <= cfg.data;
            end
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        count_next = count_reg;
        saved_next = saved_reg;
        push_entry = '0;
        push_valid = 1'b0;
        fin_en     = 1'b0;
        fin_adv    = '0;
        step       = '0;

        if (accept)
        begin
            if (item.command == pces_pkg::CMD_START)
            begin
                pos_next   = '0;
                count_next = '0;
                saved_next = '0;
                fin_en     = 1'b1;
            end
            else
            begin
                unique case (phase_reg)
                    pces_pkg::PHASE_ID:
                    begin
                        if (item.read_data[15:0] == pces_pkg::VENDOR_NONE)
                        begin
                            step    = pces_pkg::advance(pos_reg, pos_reg.func == '0);
                            fin_adv = step;
                            fin_en  = 1'b1;
                        end
                        else
                        begin
                            saved_next        = item.read_data;
                            phase_next        = pces_pkg::PHASE_CLASS;
                            push_valid        = 1'b1;
                            push_entry.kind   = pces_pkg::KIND_REQUEST;
                            push_entry.pos    = pos_reg;
                            push_entry.offset = pces_pkg::OFFSET_CLASS;
                            push_entry.count  = count_reg;
                        end
                    end
                    pces_pkg::PHASE_CLASS:
                    begin
                        if (count_reg != pces_pkg::CNT_MAX)
                        begin
                            count_next = count_reg + 17'd1;
                        end
                        phase_next               = pces_pkg::PHASE_HDR;
                        push_valid               = 1'b1;
                        push_entry.kind          = pces_pkg::KIND_RECORD;
                        push_entry.pos           = pos_reg;
                        push_entry.vendor        = saved_reg[15:0];
                        push_entry.device        = saved_reg[31:16];
                        push_entry.class_code    = item.read_data[31:24];
                        push_entry.subclass_code = item.read_data[23:16];
                        push_entry.count         = count_next;
                        push_entry.pair          = 1'b1;
                    end
                    pces_pkg::PHASE_HDR:
                    begin
                        step = pces_pkg::advance(pos_reg, (pos_reg.func == '0)
                                                 && !item.read_data[pces_pkg::MULTI_BIT]);
                        fin_adv = step;
                        fin_en  = 1'b1;
                    end
                    pces_pkg::PHASE_IDLE:
                    begin
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        if (fin_en)
        begin
            pos_next   = fin_adv.pos;
            push_valid = 1'b1;
            if (fin_adv.exhausted || (count_next >= max_reg))
            begin
                phase_next       = pces_pkg::PHASE_IDLE;
                push_entry.kind  = pces_pkg::KIND_DONE;
                push_entry.count = count_next;
            end
            else
            begin
                phase_next        = pces_pkg::PHASE_ID;
                push_entry.kind   = pces_pkg::KIND_REQUEST;
                push_entry.pos    = fin_adv.pos;
                push_entry.offset = pces_pkg::OFFSET_ID;
                push_entry.count  = count_next;
            end
        end
    end

endmodule

### rtl/core/pces_queue.sv
// Short register queue between the front and back ends of the sequencer.
// Depends on pces_pkg for the entry type.
module pces_queue
#(
    parameter int DEPTH = pces_pkg::QUEUE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    input  pces_pkg::entry_t  push_entry,
    output logic              push_ready,
    output logic              pop_valid,
    output pces_pkg::entry_t  pop_entry,
    input  logic              pop_ready
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    pces_pkg::entry_t     store [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]     fill_reg;
    logic                 do_push, do_pop;

    assign push_ready = (fill_reg != CNT_FULL);
    assign pop_valid  = (fill_reg != '0);
    assign pop_entry  = store[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - CNT_W'(1);
            end
        end
    end

endmodule

### rtl/core/pces_back.sv
// Back end: turns queue entries into result beats in an output register,
// a record entry giving a second request beat. Depends on pces_pkg, pces_ifs.
module pces_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pop_valid,
    input  pces_pkg::entry_t  pop_entry,
    output logic              pop_ready,
    pces_result_if.source     result
);

    logic                         valid_reg;
    logic                         second_reg;
    pces_pkg::entry_t             held_reg;
    pces_pkg::entry_t             beat_reg;
    pces_pkg::entry_t             hdr_beat;
    logic                         last_reg;
    logic                         load;

    assign load      = !valid_reg || result.ready;
    assign pop_ready = load && !second_reg;

    always_comb
    begin
        hdr_beat        = '0;
        hdr_beat.kind   = pces_pkg::KIND_REQUEST;
        hdr_beat.pos    = held_reg.pos;
        hdr_beat.offset = pces_pkg::OFFSET_HDR;
        hdr_beat.count  = held_reg.count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end
        else if (load)
        begin
            if (second_reg)
            begin
                valid_reg  <= 1'b1;
                second_reg <= 1'b0;
            end
            else
            begin
                valid_reg  <= pop_valid;
                second_reg <= pop_valid && pop_entry.pair;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (second_reg)
            begin
                beat_reg <= hdr_beat;
                last_reg <= 1'b1;
            end
            else
            begin
                beat_reg <= pop_entry;
                held_reg <= pop_entry;
                last_reg <= !pop_entry.pair;
            end
        end
    end

    assign result.valid           = valid_reg;
    assign result.kind            = beat_reg.kind;
    assign result.bus_number      = beat_reg.pos.bus;
    assign result.slot_number     = beat_reg.pos.slot;
    assign result.function_number = beat_reg.pos.func;
    assign result.register_offset = beat_reg.offset;
    assign result.vendor_id       = beat_reg.vendor;
    assign result.device_id       = beat_reg.device;
    assign result.class_code      = beat_reg.class_code;
    assign result.subclass_code   = beat_reg.subclass_code;
    assign result.found_count     = beat_reg.count;
    assign result.last            = last_reg;

endmodule

### rtl/core/pci_config_enumeration_sequencer.sv
// Configuration space enumeration sequencer, top level: front end, entry
// queue and back end. Depends on pces_pkg, pces_ifs and the three submodules.
//
// The block takes one input beat every cycle while its queue has room. Each
// start beat and each response beat during a walk yields one result beat,
// except the class response, which yields a device record and the header
// request; a response while idle yields nothing. The front end writes the
// queue when it accepts a beat, and the back end's output register loads the
// entry from the queue, so a beat's first result passes through the queue
// store and the output register. The sustained output rate is one beat per
// cycle while the result side is ready, set by the output register.
module pci_config_enumeration_sequencer
#(
    parameter int QUEUE_DEPTH = pces_pkg::QUEUE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    pces_item_if.sink     item,
    pces_cfg_if.sink      cfg,
    pces_result_if.source result
);

    pces_pkg::entry_t  push_entry;
    logic              push_valid;
    logic              push_ready;
    pces_pkg::entry_t  pop_entry;
    logic              pop_valid;
    logic              pop_ready;

    pces_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .cfg        (cfg),
        .push_entry (push_entry),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    pces_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_entry  (pop_entry),
        .pop_ready  (pop_ready)
    );

    pces_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_entry (pop_entry),
        .pop_ready (pop_ready),
        .result    (result)
    );

endmodule
